// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/adl_pkg.sv
// Shared constants, types and helpers for the Adler-32 checksum block.
package adl_pkg;

  localparam int LANES = 4;
  localparam int ADLER_MOD = 65521;

  // Byte count / weight width, lane product width
  localparam int CW = $clog2(LANES + 1);
  localparam int PW = 8 + CW;
  // Plain byte sum and weighted byte sum widths
  localparam int SW = $clog2(LANES * 255 + 1);
  localparam int WW = $clog2(255 * LANES * (LANES + 1) / 2 + 1);
  // Width of the unreduced second-sum total
  localparam int SUMW = 16 + CW + 1;

  // One request after the lane stage
  typedef struct packed {
    logic          start;
    logic          last;
    logic [CW-1:0] n;
    logic [SW-1:0] s;
    logic [15:0]   w;
    logic [15:0]   init_a;
    logic [15:0]   init_b;
  } step_t;

  // One conditional subtraction of the modulus
  function automatic logic [15:0] red16(input logic [16:0] v);
    logic [16:0] m;
    m = 17'(ADLER_MOD);
    return (v >= m) ? 16'(v - m) : 16'(v);
  endfunction

endpackage

// File: sv/adl_lane.sv
// One byte lane: masks the byte and weights it by its distance from the end.
module adl_lane (
  input  logic [7:0]             byte_in,
  input  logic [adl_pkg::CW-1:0] lane_idx,
  input  logic [adl_pkg::CW-1:0] n,
  output logic [7:0]             byte_out,
  output logic [adl_pkg::PW-1:0] wbyte
);
  import adl_pkg::*;

  logic          active;
  logic [CW-1:0] weight;

  // Lane is live when it falls inside the byte count
  assign active = (lane_idx < n);
  assign weight = n - lane_idx;

  // Weighted byte feeds the second sum: byte i adds (n - i) times
  always_comb begin
    byte_out = active ? byte_in : 8'd0;
    wbyte    = active ? PW'(byte_in) * PW'(weight) : '0;
  end

endmodule

// File: sv/adl_accum.sv
// Running sums: folds one merged request into both sums per cycle.
module adl_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_valid,
  input  adl_pkg::step_t      step,
  output logic [31:0]         res
);
  import adl_pkg::*;

  logic [15:0]     sum_a, sum_b;
  logic [15:0]     a_base, b_base;
  logic [15:0]     sum_a_next, sum_b_next;
  logic [SUMW-1:0] b_tot, sub;

  // Start request reloads from the initial checksum
  assign a_base = step.start ? step.init_a : sum_a;
  assign b_base = step.start ? step.init_b : sum_b;

  // First sum: the byte total stays below the modulus
  assign sum_a_next = red16(17'(a_base) + 17'(step.s));

  // Second sum: b + n*a + weighted bytes, then subtract the largest multiple
  assign b_tot = SUMW'(b_base) + SUMW'(a_base) * SUMW'(step.n) + SUMW'(step.w);

  always_comb begin
    sub = '0;
    for (int k = 1; k <= LANES + 1; k++) begin
      if (b_tot >= SUMW'(k * ADLER_MOD)) sub = SUMW'(k * ADLER_MOD);
    end
  end

  assign sum_b_next = 16'(b_tot - sub);
  assign res = {sum_b_next, sum_a_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a <= 16'd1;
      sum_b <= 16'd0;
    end else if (step_valid) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
    end
  end

endmodule

// File: sv/adl_outq.sv
// Two-entry result queue between the sums and the output channel.
module adl_outq (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] push_data,
  input  logic        pop,
  output logic        q_valid,
  output logic [31:0] q_data,
  output logic [1:0]  count
);

  logic [31:0] entry [2];
  logic        wr_ptr, rd_ptr;

  assign q_valid = (count != 2'd0);
  assign q_data  = entry[rd_ptr];

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: sv/adler32_checksum.sv
// Adler-32 checksum: one request of up to four bytes per cycle while in_stall is low.
// A request marked last passes the lane stage register and then the result queue before its checksum shows.
// The running-sum update is combinational between the sum registers.
// in_stall rises when the two-entry result queue would be full after this cycle's push and pop.
// Synchronous reset: sums go to 1 and 0, pipeline and queue empty.
module adler32_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_bytes,
  input  logic [2:0]  byte_count,
  input  logic        start_req,
  input  logic [31:0] initial_value,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] checksum
);
  import adl_pkg::*;

  logic [CW-1:0] n;
  logic [7:0]    lane_byte [LANES];
  logic [7:0]    lane_b    [LANES];
  logic [PW-1:0] lane_w    [LANES];
  logic [SW-1:0] s_sum;
  logic [WW-1:0] w_sum;
  step_t         step_d, step;
  logic          step_valid;
  logic          accept;
  logic [31:0]   res;
  logic          push, pop;
  logic [1:0]    q_count;

  assign accept = in_valid & ~in_stall;

  // Saturate the byte count at the lane count
  always_comb begin
    if (int'(byte_count) > LANES) n = CW'(LANES);
    else                          n = CW'(byte_count);
  end

  // Byte lanes
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < 4) begin : g_data
      assign lane_byte[i] = data_bytes[8*i +: 8];
    end else begin : g_zero
      assign lane_byte[i] = 8'd0;
    end
    adl_lane u_lane (
      .byte_in  (lane_byte[i]),
      .lane_idx (CW'(i)),
      .n        (n),
      .byte_out (lane_b[i]),
      .wbyte    (lane_w[i])
    );
  end

  // Merge the lanes
  always_comb begin
    s_sum = '0;
    w_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      s_sum = s_sum + SW'(lane_b[i]);
      w_sum = w_sum + WW'(lane_w[i]);
    end
  end

  always_comb begin
    step_d.start  = start_req;
    step_d.last   = last;
    step_d.n      = n;
    step_d.s      = s_sum;
    step_d.w      = red16(17'(w_sum));
    step_d.init_a = red16(17'(initial_value[15:0]));
    step_d.init_b = red16(17'(initial_value[31:16]));
  end

  // Lane stage register
  always_ff @(posedge clk) begin
    if (accept) step <= step_d;
  end

  always_ff @(posedge clk) begin
    if (rst) step_valid <= 1'b0;
    else     step_valid <= accept;
  end

  adl_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step       (step),
    .res        (res)
  );

  assign push = step_valid & step.last;
  assign pop  = out_valid & ~out_stall;

  adl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .q_valid   (out_valid),
    .q_data    (checksum),
    .count     (q_count)
  );

  // Hold off when the queue after this cycle's push and pop leaves no room
  // for the result that a new request could bring
  assign in_stall = ({1'b0, q_count} + {2'b00, push} - {2'b00, pop}) >= 3'd2;

endmodule

// File: sv/adler32_checksum_chk.sv
// Port-level checker for the Adler-32 block and its bind.
`include "assert_macros.svh"

module adler32_checksum_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] checksum
);

  `CHK_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (!in_stall && !out_valid), "not idle after reset")
  `CHK_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid, "result dropped")
  `CHK_ASSERT(a_out_stable, clk, rst, (out_valid && out_stall) |=> $stable(checksum), "result changed")
  `CHK_ASSERT(a_last_result, clk, rst, (in_valid && !in_stall && last) |=> ##1 out_valid, "no result for last request")
  `CHK_ASSERT(a_sums_reduced, clk, rst, out_valid |-> (checksum[15:0] < 16'd65521 && checksum[31:16] < 16'd65521), "sum not reduced")

endmodule

bind adler32_checksum adler32_checksum_chk u_chk (.*);

// File: tb/tb.sv
// Self-checking testbench for the streaming Adler-32 checksum block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0] MOD_BASE = 17'd65521;
  localparam int RAND_ITEMS = 1900;
  localparam int MAX_GAP = 18;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX = 10;

  // One input request as seen on the ports
  typedef struct packed {
    logic [31:0] data_bytes;
    logic [2:0]  byte_count;
    logic        start_req;
    logic [31:0] initial_value;
    logic        last;
  } req_t;

  // Directed row: request plus an optional checksum known by hand
  typedef struct packed {
    req_t        req;
    logic        has_sum;
    logic [31:0] sum;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [31:0] data_bytes = '0;
  logic [2:0]  byte_count = '0;
  logic        start_req = 1'b0;
  logic [31:0] initial_value = '0;
  logic        last = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] checksum;

  vec_t        dir_tab[$];
  logic [31:0] sum_q[$];
  logic [15:0] run_a = 16'd1;
  logic [15:0] run_b = 16'd0;
  int          err_cnt = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  adler32_checksum i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_bytes    (data_bytes),
    .byte_count    (byte_count),
    .start_req     (start_req),
    .initial_value (initial_value),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .checksum      (checksum)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Single conditional subtraction of the modulus
  function automatic logic [15:0] mod_fold(input logic [16:0] v);
    return (v >= MOD_BASE) ? 16'(v - MOD_BASE) : v[15:0];
  endfunction

  // Advance the running sums by one request; report a checksum on last
  task automatic adler_step(input req_t r, output bit emits, output logic [31:0] ck);
    int          n;
    logic [7:0]  b8;
    if (r.start_req) begin
      run_a = mod_fold({1'b0, r.initial_value[15:0]});
      run_b = mod_fold({1'b0, r.initial_value[31:16]});
    end
    n = (int'(r.byte_count) > adl_pkg::LANES) ? adl_pkg::LANES : int'(r.byte_count);
    for (int i = 0; i < n; i++) begin
      b8 = (i < 4) ? r.data_bytes[8*i +: 8] : 8'h00;
      run_a = mod_fold({1'b0, run_a} + {9'b0, b8});
      run_b = mod_fold({1'b0, run_b} + {1'b0, run_a});
    end
    emits = r.last;
    ck = {run_b, run_a};
  endtask

  task automatic add_vec(input logic [31:0] d, input logic [2:0] c, input logic s,
                         input logic [31:0] iv, input logic l,
                         input logic h, input logic [31:0] e);
    vec_t v;
    v.req = {d, c, s, iv, l};
    v.has_sum = h;
    v.sum = e;
    dir_tab.push_back(v);
  endtask

  // Present one request after a random gap, none when calm, and hold it until taken
  task automatic drive_req(input req_t r, input logic has_sum, input logic [31:0] sum_in);
    int          gap;
    bit          emits;
    logic [31:0] ck;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    data_bytes    <= r.data_bytes;
    byte_count    <= r.byte_count;
    start_req     <= r.start_req;
    initial_value <= r.initial_value;
    last          <= r.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    adler_step(r, emits, ck);
    if (emits) sum_q.push_back(has_sum ? sum_in : ck);
    @(negedge clk);
  endtask

  // Result side: compare each taken checksum with the oldest one due
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sum_q.size() == 0) begin
        if (err_cnt < REPORT_MAX)
          $display("unexpected checksum %08h with none due", checksum);
        err_cnt++;
      end else begin
        if (checksum !== sum_q[0]) begin
          if (err_cnt < REPORT_MAX)
            $display("checksum mismatch: expected %08h got %08h", sum_q[0], checksum);
          err_cnt++;
        end
        void'(sum_q.pop_front());
      end
      stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
    end else if (stall_left > 0) begin
      stall_left--;
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_left > 0);
  end

  // Watchdog on cycles where neither side moves a request
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    req_t r;
    int   sent;
    int   msg_len;
    bit   noisy;

    // Directed rows: reset state, unreduced seeds, lane extremes, odd counts
    add_vec(32'h0, 3'd0, 1'b0, 32'h0, 1'b1, 1'b1, 32'h0000_0001);
    add_vec(32'h0, 3'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h000E_000E);
    add_vec(32'h0, 3'd0, 1'b1, 32'hFFF1_FFF1, 1'b1, 1'b1, 32'h0000_0000);
    add_vec(32'h0, 3'd0, 1'b1, 32'h0000_FFFF, 1'b1, 1'b1, 32'h0000_000E);
    add_vec(32'h0, 3'd0, 1'b1, 32'hFFFF_0000, 1'b1, 1'b1, 32'h000E_0000);
    add_vec(32'hFFFF_FFFF, 3'd1, 1'b1, 32'h0, 1'b1, 1'b1, 32'h00FF_00FF);
    add_vec(32'hFFFF_FFFF, 3'd4, 1'b1, 32'h1, 1'b1, 1'b1, 32'h09FA_03FD);
    add_vec(32'hFFFF_FFFF, 3'd4, 1'b1, 32'hFFF0_FFF0, 1'b1, 1'b0, 32'h0);
    add_vec(32'h0000_0000, 3'd4, 1'b1, 32'hFFF0_FFF0, 1'b1, 1'b0, 32'h0);
    // "Wikipedia" split over three requests
    add_vec(32'h696B_6957, 3'd4, 1'b1, 32'h1, 1'b0, 1'b0, 32'h0);
    add_vec(32'h6964_6570, 3'd4, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
    add_vec(32'hFFFF_FF61, 3'd1, 1'b0, 32'h0, 1'b1, 1'b1, 32'h11E6_0398);
    // counts above the lane count saturate; zero count adds nothing
    add_vec(32'h0102_0304, 3'd5, 1'b1, 32'h1, 1'b1, 1'b0, 32'h0);
    add_vec(32'hA5A5_5A5A, 3'd6, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    add_vec(32'hDEAD_BEEF, 3'd7, 1'b0, 32'h1234_5678, 1'b1, 1'b0, 32'h0);
    add_vec(32'hFFFF_FFFF, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    add_vec(32'h8040_2010, 3'd2, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    add_vec(32'h0804_0201, 3'd3, 1'b0, 32'h0, 1'b1, 1'b0, 32'h0);
    add_vec(32'h1234_5678, 3'd4, 1'b1, 32'h1234_5678, 1'b0, 1'b0, 32'h0);
    add_vec(32'hFFFF_FFFF, 3'd4, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0);
    add_vec(32'h5555_AAAA, 3'd4, 1'b0, 32'h0, 1'b1, 1'b0, 32'h0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) drive_req(dir_tab[i].req, dir_tab[i].has_sum, dir_tab[i].sum);

    // Random messages: mostly start ... last, some noise with stray flags
    sent = 0;
    while (sent < RAND_ITEMS) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      noisy = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < msg_len; k++) begin
        case ($urandom_range(0, 7))
          0:       r.data_bytes = 32'hFFFF_FFFF;
          1:       r.data_bytes = 32'h0000_0000;
          default: r.data_bytes = $urandom;
        endcase
        r.byte_count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                   : 3'($urandom_range(1, 4));
        case ($urandom_range(0, 3))
          0:       r.initial_value = 32'h1;
          1:       r.initial_value = {16'($urandom_range(65505, 65535)),
                                      16'($urandom_range(65505, 65535))};
          default: r.initial_value = $urandom;
        endcase
        r.start_req = noisy ? 1'($urandom_range(0, 1)) : (k == 0);
        r.last      = noisy ? 1'($urandom_range(0, 1)) : (k == msg_len - 1);
        drive_req(r, 1'b0, 32'h0);
        sent++;
        if (sent % 100 == 0) calm = ($urandom_range(0, 3) == 0);
        // hold off the sender until every due checksum has come back
        if (sent == RAND_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (sum_q.size() != 0) @(negedge clk);
          repeat (DRAIN_CYCLES) @(negedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
